>>> design/desf_pkg.sv
// Shared types and constants for the double exponential smoothing trend filter.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package desf_pkg;

   // request kinds
   localparam logic REQ_SAMPLE  = 1'b0;
   localparam logic REQ_PREDICT = 1'b1;

   // register index, taken from paddr[2]
   localparam logic REG_ALPHA = 1'b0;
   localparam logic REG_BETA  = 1'b1;

   localparam int unsigned COEF_WIDTH = 16;
   localparam logic [COEF_WIDTH-1:0] ALPHA_RESET = 16'd32768;
   localparam logic [COEF_WIDTH-1:0] BETA_RESET  = 16'd32768;

   // blend unit operand select
   localparam logic BLEND_LEVEL = 1'b0;
   localparam logic BLEND_TREND = 1'b1;

   typedef struct packed {
      logic capture;
      logic mul_step;
      logic ext_load;
      logic blend_prod;
      logic blend_load;
      logic blend_sel;
      logic div_init;
      logic div_step;
      logic q_load;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_predict;
      logic primed;
      logic dt_zero;
   } dp_status_type;

endpackage

>>> design/desf_ctrl.sv
// Sequencer for the smoothing filter: steps the datapath through multiply,
// blend, divide and commit, and owns the word handshakes. Uses desf_pkg.
`timescale 1ns / 1ps

module desf_ctrl #(
   parameter int VALUE_WIDTH = 32,
   parameter int TIME_WIDTH  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output desf_pkg::dp_cmd_type      cmd,
   input  desf_pkg::dp_status_type   status
);
   import desf_pkg::*;

   localparam int CMAX = (TIME_WIDTH > VALUE_WIDTH + 1) ? TIME_WIDTH - 1 : VALUE_WIDTH;
   localparam int CW   = $clog2(CMAX + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_EXT   = 4'd2;
   localparam logic [3:0] S_BLA   = 4'd3;
   localparam logic [3:0] S_BLB   = 4'd4;
   localparam logic [3:0] S_DINIT = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_Q     = 4'd7;
   localparam logic [3:0] S_BTA   = 4'd8;
   localparam logic [3:0] S_BTB   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               cnt_in      = CW'(TIME_WIDTH - 1);
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_EXT;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         S_EXT: begin
            cmd.ext_load = 1'b1;
            if (status.is_predict || !status.primed) begin
               state_in = S_DONE;
            end else begin
               state_in = S_BLA;
            end
         end
         S_BLA: begin
            cmd.blend_prod = 1'b1;
            cmd.blend_sel  = BLEND_LEVEL;
            state_in       = S_BLB;
         end
         S_BLB: begin
            cmd.blend_load = 1'b1;
            cmd.blend_sel  = BLEND_LEVEL;
            state_in       = status.dt_zero ? S_DONE : S_DINIT;
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = CW'(VALUE_WIDTH);
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_Q;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         S_Q: begin
            cmd.q_load = 1'b1;
            state_in   = S_BTA;
         end
         S_BTA: begin
            cmd.blend_prod = 1'b1;
            cmd.blend_sel  = BLEND_TREND;
            state_in       = S_BTB;
         end
         S_BTB: begin
            cmd.blend_load = 1'b1;
            cmd.blend_sel  = BLEND_TREND;
            state_in       = S_DONE;
         end
         S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/desf_datapath.sv
// Filter state and arithmetic: shift-add multiply, blend multiplier,
// restoring divider, saturation and the result register. Uses desf_pkg.
`timescale 1ns / 1ps

module desf_datapath #(
   parameter int VALUE_WIDTH = 32,
   parameter int TIME_WIDTH  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  desf_pkg::dp_cmd_type      cmd,
   output desf_pkg::dp_status_type   status,
   input  logic                      req_type,
   input  logic [31:0]               sample_value,
   input  logic [31:0]               time_stamp,
   input  logic [15:0]               alpha,
   input  logic [15:0]               beta,
   output logic [31:0]               out_level,
   output logic [31:0]               out_trend
);
   import desf_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int T  = TIME_WIDTH;
   localparam int XT = (T > 32) ? T : 32;
   localparam int SW = ((W > 32) ? W : 32) + 2;
   localparam int PW = W + T;
   localparam int BW = W + 1 + COEF_WIDTH;

   localparam logic signed [SW-1:0] VMAX_S = SW'((65'd1 << (W - 1)) - 65'd1);
   localparam logic signed [SW-1:0] VMIN_S = ~VMAX_S;
   localparam logic signed [SW-1:0] OMAX_S = SW'(32'h7FFF_FFFF);
   localparam logic signed [SW-1:0] OMIN_S = ~OMAX_S;
   localparam logic [PW-1:0]        LIM_POS = PW'((65'd1 << (W - 1)) - 65'd1);
   localparam logic [PW-1:0]        LIM_NEG = PW'(65'd1 << (W - 1));

   function automatic logic [W-1:0] sat_v(input logic signed [SW-1:0] v);
      logic [W-1:0] r;
      if (v > VMAX_S) begin
         r = VMAX_S[W-1:0];
      end else if (v < VMIN_S) begin
         r = VMIN_S[W-1:0];
      end else begin
         r = v[W-1:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] out32(input logic [W-1:0] v);
      logic signed [SW-1:0] e;
      logic [31:0]          r;
      e = SW'($signed(v));
      if (e > OMAX_S) begin
         r = OMAX_S[31:0];
      end else if (e < OMIN_S) begin
         r = OMIN_S[31:0];
      end else begin
         r = e[31:0];
      end
      return r;
   endfunction

   // filter state
   logic         primed_ff, primed_in;
   logic [W-1:0] level_ff, level_in;
   logic [W-1:0] trend_ff, trend_in;
   logic [T-1:0] last_time_ff, last_time_in;

   // captured request
   logic         req_type_ff, req_type_in;
   logic [W-1:0] sample_ff, sample_in;
   logic [T-1:0] time_ff, time_in;
   logic [T-1:0] dt_ff, dt_in;

   // multiplier
   logic [W-1:0]  ma_ff, ma_in;
   logic [T-1:0]  mb_ff, mb_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic          mneg_ff, mneg_in;
   logic [W-1:0]  x_ff, x_in;

   // blend
   logic [BW-1:0] pr_ff, pr_in;
   logic          bneg_ff, bneg_in;
   logic [W-1:0]  nl_ff, nl_in;
   logic [W-1:0]  nt_ff, nt_in;

   // divider
   logic [W:0]    quo_ff, quo_in;
   logic [T-1:0]  rem_ff, rem_in;
   logic          qneg_ff, qneg_in;
   logic [W-1:0]  q_ff, q_in;

   logic [31:0]   out_level_ff, out_level_in;
   logic [31:0]   out_trend_ff, out_trend_in;

   // combinational terms
   logic [XT-1:0] t_ext;
   logic [T-1:0]  t_now;
   logic [T-1:0]  dt_now;
   logic [PW-1:0] acc_cl;
   logic [W-1:0]  prod_s;
   logic [W-1:0]  b_base, b_target;
   logic [15:0]   b_f;
   logic [W:0]    b_diff, b_dmag;
   logic [BW:0]   pr_r;
   logic [W+1:0]  b_inc, b_res;
   logic [W:0]    dl, dl_mag;
   logic [T-1:0]  dv;
   logic [T:0]    rs;
   logic [W+1:0]  qx, qs;
   logic [W-1:0]  new_trend;

   assign out_level = out_level_ff;
   assign out_trend = out_trend_ff;

   assign status.is_predict = (req_type_ff == REQ_PREDICT);
   assign status.primed     = primed_ff;
   assign status.dt_zero    = (dt_ff == '0);

   always_comb begin
      t_ext  = XT'(time_stamp);
      t_now  = t_ext[T-1:0];
      dt_now = t_now - last_time_ff;

      // clamp the magnitude product to the signed range, then apply the sign
      if (acc_ff > (mneg_ff ? LIM_NEG : LIM_POS)) begin
         acc_cl = mneg_ff ? LIM_NEG : LIM_POS;
      end else begin
         acc_cl = acc_ff;
      end
      prod_s = mneg_ff ? (W'(0) - acc_cl[W-1:0]) : acc_cl[W-1:0];

      // blend: base + floor(f * (target - base) / 2^16)
      if (cmd.blend_sel == BLEND_TREND) begin
         b_base   = trend_ff;
         b_target = q_ff;
         b_f      = beta;
      end else begin
         b_base   = x_ff;
         b_target = sample_ff;
         b_f      = alpha;
      end
      b_diff = {b_target[W-1], b_target} - {b_base[W-1], b_base};
      b_dmag = b_diff[W] ? ((W + 1)'(0) - b_diff) : b_diff;
      pr_r   = {1'b0, pr_ff} + (bneg_ff ? (BW + 1)'(16'hFFFF) : '0);
      b_inc  = pr_r[BW:COEF_WIDTH];
      if (bneg_ff) begin
         b_res = {{2{b_base[W-1]}}, b_base} - b_inc;
      end else begin
         b_res = {{2{b_base[W-1]}}, b_base} + b_inc;
      end

      // divider operands
      dl     = {nl_ff[W-1], nl_ff} - {level_ff[W-1], level_ff};
      dl_mag = dl[W] ? ((W + 1)'(0) - dl) : dl;
      dv     = dt_ff[T-1] ? (T'(0) - dt_ff) : dt_ff;
      rs     = {rem_ff, quo_ff[W]};
      qx     = {1'b0, quo_ff};
      qs     = qneg_ff ? ((W + 2)'(0) - qx) : qx;

      new_trend = status.dt_zero ? trend_ff : nt_ff;

      // defaults: hold
      primed_in    = primed_ff;
      level_in     = level_ff;
      trend_in     = trend_ff;
      last_time_in = last_time_ff;
      req_type_in  = req_type_ff;
      sample_in    = sample_ff;
      time_in      = time_ff;
      dt_in        = dt_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      acc_in       = acc_ff;
      mneg_in      = mneg_ff;
      x_in         = x_ff;
      pr_in        = pr_ff;
      bneg_in      = bneg_ff;
      nl_in        = nl_ff;
      nt_in        = nt_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      qneg_in      = qneg_ff;
      q_in         = q_ff;
      out_level_in = out_level_ff;
      out_trend_in = out_trend_ff;

      if (cmd.capture) begin
         req_type_in = req_type;
         sample_in   = sat_v(SW'($signed(sample_value)));
         time_in     = t_now;
         dt_in       = dt_now;
         ma_in       = trend_ff[W-1] ? (W'(0) - trend_ff) : trend_ff;
         mb_in       = dt_now[T-1] ? (T'(0) - dt_now) : dt_now;
         acc_in      = '0;
         mneg_in     = trend_ff[W-1] ^ dt_now[T-1];
      end

      if (cmd.mul_step) begin
         acc_in = {acc_ff[PW-2:0], 1'b0} + (mb_ff[T-1] ? PW'(ma_ff) : '0);
         mb_in  = {mb_ff[T-2:0], 1'b0};
      end

      if (cmd.ext_load) begin
         x_in = sat_v(SW'($signed(level_ff)) + SW'($signed(prod_s)));
      end

      if (cmd.blend_prod) begin
         pr_in   = BW'(b_dmag) * BW'(b_f);
         bneg_in = b_diff[W];
      end

      if (cmd.blend_load) begin
         if (cmd.blend_sel == BLEND_TREND) begin
            nt_in = b_res[W-1:0];
         end else begin
            nl_in = b_res[W-1:0];
         end
      end

      if (cmd.div_init) begin
         quo_in  = dl_mag;
         rem_in  = '0;
         qneg_in = dl[W] ^ dt_ff[T-1];
      end

      if (cmd.div_step) begin
         if (rs >= {1'b0, dv}) begin
            rem_in = T'(rs - {1'b0, dv});
            quo_in = {quo_ff[W-1:0], 1'b1};
         end else begin
            rem_in = rs[T-1:0];
            quo_in = {quo_ff[W-1:0], 1'b0};
         end
      end

      if (cmd.q_load) begin
         q_in = sat_v(SW'($signed(qs)));
      end

      if (cmd.commit) begin
         if (req_type_ff == REQ_PREDICT) begin
            out_level_in = out32(x_ff);
            out_trend_in = out32(trend_ff);
         end else if (!primed_ff) begin
            primed_in    = 1'b1;
            level_in     = sample_ff;
            trend_in     = '0;
            last_time_in = time_ff;
            out_level_in = out32(sample_ff);
            out_trend_in = '0;
         end else begin
            level_in     = nl_ff;
            trend_in     = new_trend;
            last_time_in = time_ff;
            out_level_in = out32(nl_ff);
            out_trend_in = out32(new_trend);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         level_ff     <= '0;
         trend_ff     <= '0;
         last_time_ff <= '0;
      end else begin
         primed_ff    <= primed_in;
         level_ff     <= level_in;
         trend_ff     <= trend_in;
         last_time_ff <= last_time_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff  <= req_type_in;
      sample_ff    <= sample_in;
      time_ff      <= time_in;
      dt_ff        <= dt_in;
      ma_ff        <= ma_in;
      mb_ff        <= mb_in;
      acc_ff       <= acc_in;
      mneg_ff      <= mneg_in;
      x_ff         <= x_in;
      pr_ff        <= pr_in;
      bneg_ff      <= bneg_in;
      nl_ff        <= nl_in;
      nt_ff        <= nt_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      qneg_ff      <= qneg_in;
      q_ff         <= q_in;
      out_level_ff <= out_level_in;
      out_trend_ff <= out_trend_in;
   end

endmodule

>>> design/double_exp_smoothing_trend_filter.sv
// Top level of the double exponential smoothing trend filter: register port,
// controller and datapath. Depends on desf_pkg, desf_ctrl, desf_datapath.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_valid / req_stall): one word per request. req_type
//   selects a sample update (level/trend blend, time stamp stored) or a
//   prediction of the level at req_time_stamp (state untouched).
//   Result channel (rsp_valid / rsp_stall): one word per request carrying the
//   new or predicted level and the current trend, both Q16.16, saturated.
//   Register port: alpha at byte 0, beta at byte 4, Q0.16; write only while
//   no request is in flight. Reads return the stored value.
// Sequence: a prediction or a first sample completes after the bit-serial
//   extrapolation multiply (T steps, T = TIME_WIDTH); a sample with zero
//   elapsed time adds the level blend; other samples add the level blend,
//   the restoring divide by elapsed time (V + 1 steps, V = VALUE_WIDTH)
//   and the trend blend. One request is in flight at a time; the next is
//   taken the cycle after its result is loaded.
// Reset clears the filter (unprimed, level, trend and last time zero) and
//   loads alpha and beta with one half.
// A stalled result holds in the output register; the next request may be
//   accepted and processed meanwhile, and it waits to commit until the
//   held word is taken.

module double_exp_smoothing_trend_filter #(
   parameter int VALUE_WIDTH = 32,
   parameter int TIME_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_sample_value,
   input  logic [31:0] req_time_stamp,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_level,
   output logic [31:0] rsp_out_trend,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import desf_pkg::*;

   logic [COEF_WIDTH-1:0] alpha_ff, alpha_in;
   logic [COEF_WIDTH-1:0] beta_ff, beta_in;
   logic                  csr_wr;
   dp_cmd_type            cmd;
   dp_status_type         status;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   // register writes; word address taken from paddr[2]
   always_comb begin
      alpha_in = alpha_ff;
      beta_in  = beta_ff;
      if (csr_wr) begin
         case (paddr[2])
            REG_ALPHA: alpha_in = pwdata[COEF_WIDTH-1:0];
            REG_BETA:  beta_in  = pwdata[COEF_WIDTH-1:0];
            default:   alpha_in = alpha_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_ALPHA: prdata = 32'(alpha_ff);
         REG_BETA:  prdata = 32'(beta_ff);
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         beta_ff  <= BETA_RESET;
      end else begin
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
      end
   end

   desf_ctrl #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   desf_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_type     (req_type),
      .sample_value (req_sample_value),
      .time_stamp   (req_time_stamp),
      .alpha        (alpha_ff),
      .beta         (beta_ff),
      .out_level    (rsp_out_level),
      .out_trend    (rsp_out_trend)
   );

endmodule
